// File: hdl/lmrsd_pkg.sv
// Shared types and constants for the LED matrix row scan driver.
// No dependencies; every other file of the block but lmrsd_if imports this package.
package lmrsd_pkg;

    localparam int LMRSD_PANEL_ROWS = 32;
    localparam int LMRSD_PANEL_COLS = 64;

    // Width of the configuration address bus and the data bus.
    localparam int LMRSD_PADDR_W = 3;
    localparam int LMRSD_PDATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_BIT_PLANE = 1'b0;
    localparam logic REG_ON_TICKS  = 1'b1;

    // Item kinds on the pixel channel.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Colour channel codes.
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    localparam int LANES = 6;

    // Panel pin levels, one result transfer.
    typedef struct packed {
        logic [3:0] row_addr;
        logic       red_top;
        logic       green_top;
        logic       blue_top;
        logic       red_bottom;
        logic       green_bottom;
        logic       blue_bottom;
        logic       shift_clock;
        logic       latch;
        logic       blank;
    } t_pins;

endpackage

// File: hdl/lmrsd_if.sv
// Channel interfaces: pixel/tick items in, panel pin levels out.
// Plain valid/ready handshakes; no package dependency.
interface lmrsd_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [1:0] channel;
    logic [4:0] pixel_row;
    logic [5:0] pixel_col;
    logic [7:0] pixel_value;

    modport source (output valid, mode, channel, pixel_row, pixel_col, pixel_value,
                    input ready);
    modport sink   (input valid, mode, channel, pixel_row, pixel_col, pixel_value,
                    output ready);
endinterface

interface lmrsd_pin_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_addr;
    logic       red_top;
    logic       green_top;
    logic       blue_top;
    logic       red_bottom;
    logic       green_bottom;
    logic       blue_bottom;
    logic       shift_clock;
    logic       latch;
    logic       blank;

    modport source (output valid, row_addr, red_top, green_top, blue_top, red_bottom,
                    green_bottom, blue_bottom, shift_clock, latch, blank,
                    input ready);
    modport sink   (input valid, row_addr, red_top, green_top, blue_top, red_bottom,
                    green_bottom, blue_bottom, shift_clock, latch, blank,
                    output ready);
endinterface

// File: hdl/lmrsd_cfg.sv
// APB-style register file holding bit_plane and on_ticks.
// Depends on lmrsd_pkg for bus widths and register indexes.
module lmrsd_cfg
    import lmrsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [LMRSD_PADDR_W-1:0] paddr,
    input  logic [LMRSD_PDATA_W-1:0] pwdata,
    output logic [LMRSD_PDATA_W-1:0] prdata,
    output logic                     pready,
    output logic [2:0]               o_bit_plane,
    output logic [15:0]              o_on_ticks
);

    logic [2:0]  r_bit_plane;
    logic [15:0] r_on_ticks;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_plane <= 3'd7;
            r_on_ticks  <= 16'd10;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BIT_PLANE: r_bit_plane <= pwdata[2:0];
                REG_ON_TICKS:  r_on_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIT_PLANE: prdata = LMRSD_PDATA_W'(r_bit_plane);
            REG_ON_TICKS:  prdata = LMRSD_PDATA_W'(r_on_ticks);
            default:       prdata = '0;
        endcase
    end

    assign o_bit_plane = r_bit_plane;
    assign o_on_ticks  = r_on_ticks;

endmodule

// File: hdl/lmrsd_store.sv
// Frame store: one word per row pair and column, six byte lanes (top RGB,
// bottom RGB), with a clearing pass after reset. Depends on lmrsd_pkg.
module lmrsd_store
    import lmrsd_pkg::*;
#(
    parameter int PANEL_ROWS = LMRSD_PANEL_ROWS,
    parameter int PANEL_COLS = LMRSD_PANEL_COLS,
    localparam int HALF   = PANEL_ROWS / 2,
    localparam int PAIR_W = (HALF > 1) ? $clog2(HALF) : 1,
    localparam int COL_W  = $clog2(PANEL_COLS),
    localparam int ADDR_W = PAIR_W + COL_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [2:0]                   i_wr_lane,
    input  logic [7:0]                   i_wr_data,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    input  logic [2:0]                   i_bit_plane,
    output logic [LANES-1:0]             o_bits,
    output logic                         o_clr_done
);

    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int WORD_W = 8 * LANES;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd;
    logic              r_byp_en;
    logic [2:0]        r_byp_lane;
    logic [7:0]        r_byp_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_done;
    logic              wr_ok;

    assign wr_ok = r_clr_done && i_wr_en;

    // Memory array: clearing writes whole words of ones, pixel writes one lane.
    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            r_mem[r_clr_addr] <= '1;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_data;
        end
        r_rd       <= r_mem[i_rd_addr];
        r_byp_lane <= i_wr_lane;
        r_byp_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
            r_byp_en   <= 1'b0;
        end else begin
            r_byp_en <= wr_ok && (i_wr_addr == i_rd_addr);
            if (!r_clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
        end
    end

    // A write at the same edge as the read is merged in here.
    always_comb begin
        logic [7:0] lane_byte;
        for (int k = 0; k < LANES; k++) begin
            lane_byte = (r_byp_en && r_byp_lane == 3'(k)) ? r_byp_data
                                                            : r_rd[k*8 +: 8];
            o_bits[k] = lane_byte[i_bit_plane];
        end
    end

    assign o_clr_done = r_clr_done;

    clr_addr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_done |=> r_clr_done)
        else $error("clearing pass restarted");

    clr_blocks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_done |=> !r_byp_en)
        else $error("bypass armed during clearing pass");

    byp_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_en |-> $past(i_wr_en) && $past(i_wr_addr) == $past(i_rd_addr))
        else $error("bypass without matching write");

endmodule

// File: hdl/lmrsd_scan.sv
// Scan sequencer: waveform phase machine, column and row counters, on-time
// counter and the pin state register. Depends on lmrsd_pkg for t_pins.
module lmrsd_scan
    import lmrsd_pkg::*;
#(
    parameter int PANEL_ROWS = LMRSD_PANEL_ROWS,
    parameter int PANEL_COLS = LMRSD_PANEL_COLS,
    localparam int HALF   = PANEL_ROWS / 2,
    localparam int PAIR_W = (HALF > 1) ? $clog2(HALF) : 1,
    localparam int COL_W  = $clog2(PANEL_COLS),
    localparam int ADDR_W = PAIR_W + COL_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [15:0]          i_on_ticks,
    input  logic [LANES-1:0]     i_bits,
    output logic [ADDR_W-1:0]    o_rd_addr,
    output t_pins                o_pins
);

    // Pin levels after reset: everything low but blank, so the panel is dark.
    localparam t_pins PINS_IDLE = '{
        row_addr:     4'd0,
        red_top:      1'b0,
        green_top:    1'b0,
        blue_top:     1'b0,
        red_bottom:   1'b0,
        green_bottom: 1'b0,
        blue_bottom:  1'b0,
        shift_clock:  1'b0,
        latch:        1'b0,
        blank:        1'b1
    };

    typedef enum logic [7:0] {
        PH_ADDR = 8'b0000_0001,
        PH_DATA = 8'b0000_0010,
        PH_CLKH = 8'b0000_0100,
        PH_CLKL = 8'b0000_1000,
        PH_LATH = 8'b0001_0000,
        PH_LATL = 8'b0010_0000,
        PH_UNBL = 8'b0100_0000,
        PH_WAIT = 8'b1000_0000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [PAIR_W-1:0] r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [15:0]       r_wait, n_wait;
    t_pins             r_pins, n_pins;

    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_col   = r_col;
        n_wait  = r_wait;
        n_pins  = r_pins;
        if (i_step) begin
            unique case (r_phase)
                PH_ADDR: begin
                    n_pins              = '0;
                    n_pins.row_addr     = 4'(r_row);
                    n_pins.blank        = 1'b1;
                    n_phase             = PH_DATA;
                end
                PH_DATA: begin
                    n_pins.red_top      = i_bits[0];
                    n_pins.green_top    = i_bits[1];
                    n_pins.blue_top     = i_bits[2];
                    n_pins.red_bottom   = i_bits[3];
                    n_pins.green_bottom = i_bits[4];
                    n_pins.blue_bottom  = i_bits[5];
                    n_pins.shift_clock  = 1'b0;
                    n_phase             = PH_CLKH;
                end
                PH_CLKH: begin
                    n_pins.shift_clock  = 1'b1;
                    n_phase             = PH_CLKL;
                end
                PH_CLKL: begin
                    n_pins.shift_clock  = 1'b0;
                    n_pins.red_top      = 1'b0;
                    n_pins.green_top    = 1'b0;
                    n_pins.blue_top     = 1'b0;
                    n_pins.red_bottom   = 1'b0;
                    n_pins.green_bottom = 1'b0;
                    n_pins.blue_bottom  = 1'b0;
                    if (r_col == '0) begin
                        n_phase = PH_LATH;
                    end else begin
                        n_col   = r_col - 1'b1;
                        n_phase = PH_DATA;
                    end
                end
                PH_LATH: begin
                    n_pins.latch = 1'b1;
                    n_pins.blank = 1'b1;
                    n_phase      = PH_LATL;
                end
                PH_LATL: begin
                    n_pins.latch = 1'b0;
                    n_phase      = PH_UNBL;
                end
                PH_UNBL: begin
                    n_pins.blank = 1'b0;
                    n_wait       = i_on_ticks;
                    n_phase      = PH_WAIT;
                end
                PH_WAIT: begin
                    if (r_wait != '0) begin
                        n_wait       = r_wait - 1'b1;
                        n_pins.blank = 1'b0;
                    end else begin
                        n_pins.blank = 1'b1;
                        n_col        = COL_W'(PANEL_COLS - 1);
                        n_row        = (r_row == PAIR_W'(HALF - 1)) ? '0 : r_row + 1'b1;
                        n_phase      = PH_ADDR;
                    end
                end
                default: n_phase = PH_ADDR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ADDR;
            r_row   <= '0;
            r_col   <= COL_W'(PANEL_COLS - 1);
            r_wait  <= '0;
            r_pins  <= PINS_IDLE;
        end else begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_col   <= n_col;
            r_wait  <= n_wait;
            r_pins  <= n_pins;
        end
    end

    // The store is read at the scan position the next item will see.
    assign o_rd_addr = {n_row, n_col};
    assign o_pins    = r_pins;

    clk_while_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins.shift_clock |-> r_pins.blank && !r_pins.latch)
        else $error("shift clock high while panel lit or latching");

    latch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pins.latch |-> r_phase == PH_LATL && r_pins.blank)
        else $error("latch high outside latch phase");

    wait_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_WAIT && r_wait != '0 |=> !r_pins.blank)
        else $error("panel blanked before on-time ran out");

endmodule

// File: hdl/led_matrix_row_scan_driver_unit.sv
// Top level of the LED matrix row scan driver: input register, frame store,
// scan sequencer, register file. Depends on lmrsd_pkg, lmrsd_if and submodules.
//
//  Channel  Kind             Carries
//  -------  ---------------  --------------------------------------------------
//  i_pix    valid/ready in   pixel byte write (mode 0) or one tick (mode 1)
//  o_pin    valid/ready out  panel pin levels after each item, one per item
//  APB      psel/penable     bit_plane at 0x0, on_ticks at 0x4, pready tied high
//
// One item is taken every clock cycle while o_pin does not stall; each result
// passes the input register, then the pin register, before it leaves.
// After reset the frame store runs a clearing pass over 2**(pair bits + column
// bits) words (1024 for a 32x64 panel); i_pix.ready stays low until it ends.
// A stall on o_pin holds the pin register and the input register; ready drops
// only once both are full.
module led_matrix_row_scan_driver_unit
    import lmrsd_pkg::*;
#(
    parameter int PANEL_ROWS = LMRSD_PANEL_ROWS,
    parameter int PANEL_COLS = LMRSD_PANEL_COLS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lmrsd_pix_if.sink                i_pix,
    lmrsd_pin_if.source              o_pin,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [LMRSD_PADDR_W-1:0] paddr,
    input  logic [LMRSD_PDATA_W-1:0] pwdata,
    output logic [LMRSD_PDATA_W-1:0] prdata,
    output logic                     pready
);

    localparam int HALF   = PANEL_ROWS / 2;
    localparam int PAIR_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int COL_W  = $clog2(PANEL_COLS);
    localparam int ADDR_W = PAIR_W + COL_W;

    // Input register.
    logic       r_in_vld;
    logic       r_in_mode;
    logic [1:0] r_in_chan;
    logic [4:0] r_in_row;
    logic [5:0] r_in_col;
    logic [7:0] r_in_val;
    logic       r_out_vld;

    logic              adv;
    logic              proc;
    logic              clr_done;
    logic [2:0]        bit_plane;
    logic [15:0]       on_ticks;
    logic [LANES-1:0]  bits;
    logic [ADDR_W-1:0] rd_addr;
    t_pins             pins;

    // Write decode: the row picks the pair and the half, the half the lane group.
    logic [6:0]        row_x;
    logic [8:0]        col_x;
    logic              row_hi;
    logic              wr_en;
    logic [PAIR_W-1:0] wr_pair;
    logic [2:0]        wr_lane;

    // The pin register drops its result only when it is empty or being taken.
    assign adv         = !r_out_vld || o_pin.ready;
    assign proc        = r_in_vld && adv;
    assign i_pix.ready = clr_done && (!r_in_vld || adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_in_vld <= i_pix.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_in_mode <= i_pix.mode;
            r_in_chan <= i_pix.channel;
            r_in_row  <= i_pix.pixel_row;
            r_in_col  <= i_pix.pixel_col;
            r_in_val  <= i_pix.pixel_value;
        end
    end

    assign row_x   = 7'(r_in_row);
    assign col_x   = 9'(r_in_col);
    assign row_hi  = row_x >= 7'(HALF);
    assign wr_pair = PAIR_W'(row_hi ? row_x - 7'(HALF) : row_x);
    assign wr_lane = 3'(r_in_chan) + (row_hi ? 3'd3 : 3'd0);

    // Channel three and positions beyond the panel are dropped.
    always_comb begin
        wr_en = 1'b0;
        if (proc && r_in_mode == MODE_WRITE && row_x < 7'(PANEL_ROWS)
                && col_x < 9'(PANEL_COLS)) begin
            case (r_in_chan) inside
                CHAN_RED, CHAN_GREEN, CHAN_BLUE: wr_en = 1'b1;
                default:                         wr_en = 1'b0;
            endcase
        end
    end

    lmrsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_bit_plane (bit_plane),
        .o_on_ticks  (on_ticks)
    );

    lmrsd_store #(
        .PANEL_ROWS (PANEL_ROWS),
        .PANEL_COLS (PANEL_COLS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   ({wr_pair, COL_W'(r_in_col)}),
        .i_wr_lane   (wr_lane),
        .i_wr_data   (r_in_val),
        .i_rd_addr   (rd_addr),
        .i_bit_plane (bit_plane),
        .o_bits      (bits),
        .o_clr_done  (clr_done)
    );

    lmrsd_scan #(
        .PANEL_ROWS (PANEL_ROWS),
        .PANEL_COLS (PANEL_COLS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (proc && r_in_mode == MODE_TICK),
        .i_on_ticks (on_ticks),
        .i_bits     (bits),
        .o_rd_addr  (rd_addr),
        .o_pins     (pins)
    );

    // The pin register in the sequencer is the result register.
    assign o_pin.valid        = r_out_vld;
    assign o_pin.row_addr     = pins.row_addr;
    assign o_pin.red_top      = pins.red_top;
    assign o_pin.green_top    = pins.green_top;
    assign o_pin.blue_top     = pins.blue_top;
    assign o_pin.red_bottom   = pins.red_bottom;
    assign o_pin.green_bottom = pins.green_bottom;
    assign o_pin.blue_bottom  = pins.blue_bottom;
    assign o_pin.shift_clock  = pins.shift_clock;
    assign o_pin.latch        = pins.latch;
    assign o_pin.blank        = pins.blank;

    clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_done |-> !r_in_vld && !r_out_vld)
        else $error("item in flight during clearing pass");

    proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_vld)
        else $error("processed item produced no result");

    write_only_on_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> proc && r_in_mode == MODE_WRITE)
        else $error("frame store written without a pixel write");

endmodule

// File: sim/tb.sv
// Testbench for led_matrix_row_scan_driver_unit: a scan-order predictor checks every pin transfer.
// Depends on lmrsd_pkg, the lmrsd_pix_if and lmrsd_pin_if interfaces, and the unit's RTL.
// Covers directed pixel writes, a two-pair sweep, a longer on-time and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmrsd_pkg::*;

    // Longest run of cycles without any transfer before the run is declared hung.
    // It must cover the frame store clearing pass after reset.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int FRAME_BYTES = 3 * LMRSD_PANEL_ROWS * LMRSD_PANEL_COLS;
    // Ticks spent on one row pair with an on-time of zero: address, three per column,
    // latch high, latch low, unblank and the final wait tick.
    localparam int PAIR_TICKS = 1 + 3 * LMRSD_PANEL_COLS + 4;
    // On-time used for the longer unblanked wait.
    localparam int LONG_ON_TICKS = 200;
    // Items sent in each phase of the random test.
    localparam int RANDOM_ITEMS = 80;
    // The fourth channel code has no store behind it, so a write with it is dropped.
    localparam logic [1:0] CHAN_SPARE = 2'd3;

    typedef enum logic [2:0] {
        WAVE_ADDR,
        WAVE_DATA,
        WAVE_CLK_HI,
        WAVE_CLK_LO,
        WAVE_LATCH_HI,
        WAVE_LATCH_LO,
        WAVE_UNBLANK,
        WAVE_ON_WAIT
    } t_wave;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [LMRSD_PADDR_W-1:0] paddr;
    logic [LMRSD_PDATA_W-1:0] pwdata;
    logic [LMRSD_PDATA_W-1:0] prdata;
    logic                     pready;

    lmrsd_pix_if pix_ch ();
    lmrsd_pin_if pin_ch ();

    led_matrix_row_scan_driver_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_pin   (pin_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted panel state. The scan position, the waveform phase and the pin
    // levels advance only on ticks; pixel writes touch nothing but the store.
    logic [7:0]  frame_bytes [FRAME_BYTES];
    logic [3:0]  scan_row;
    logic [5:0]  scan_col;
    t_wave       wave;
    logic [15:0] on_left;
    t_pins       pins;
    logic [2:0]  cfg_plane;
    logic [15:0] cfg_on;

    // Pin levels still owed by the unit, oldest first.
    t_pins pending_pins[$];

    int err_count    = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_panel_model();
        foreach (frame_bytes[k]) frame_bytes[k] = 8'hff;
        scan_row  = '0;
        scan_col  = '1;
        wave      = WAVE_ADDR;
        on_left   = '0;
        pins      = '0;
        pins.blank = 1'b1;
        cfg_plane = 3'd7;
        cfg_on    = 16'd10;
    endtask

    // Bit of the shown plane for one channel and panel row at the current column.
    // The store is laid out channel-major, then row, then column.
    function automatic logic shown_bit(logic [1:0] ch, logic [4:0] row);
        logic [7:0] byte_val;
        byte_val = frame_bytes[{ch, row, scan_col}];
        return byte_val[cfg_plane];
    endfunction

    task automatic clear_colour();
        pins.red_top      = 1'b0;
        pins.green_top    = 1'b0;
        pins.blue_top     = 1'b0;
        pins.red_bottom   = 1'b0;
        pins.green_bottom = 1'b0;
        pins.blue_bottom  = 1'b0;
    endtask

    // One tick: move the pin waveform on by one phase.
    task automatic advance_waveform();
        case (wave)
            WAVE_ADDR: begin
                pins.row_addr    = scan_row;
                clear_colour();
                pins.shift_clock = 1'b0;
                pins.latch       = 1'b0;
                pins.blank       = 1'b1;
                wave             = WAVE_DATA;
            end
            WAVE_DATA: begin
                // The upper half row is scan_row, the lower one sits half a panel below.
                pins.red_top      = shown_bit(CHAN_RED,   {1'b0, scan_row});
                pins.green_top    = shown_bit(CHAN_GREEN, {1'b0, scan_row});
                pins.blue_top     = shown_bit(CHAN_BLUE,  {1'b0, scan_row});
                pins.red_bottom   = shown_bit(CHAN_RED,   {1'b1, scan_row});
                pins.green_bottom = shown_bit(CHAN_GREEN, {1'b1, scan_row});
                pins.blue_bottom  = shown_bit(CHAN_BLUE,  {1'b1, scan_row});
                pins.shift_clock  = 1'b0;
                wave              = WAVE_CLK_HI;
            end
            WAVE_CLK_HI: begin
                pins.shift_clock = 1'b1;
                wave             = WAVE_CLK_LO;
            end
            WAVE_CLK_LO: begin
                pins.shift_clock = 1'b0;
                clear_colour();
                if (scan_col == '0) begin
                    wave = WAVE_LATCH_HI;
                end else begin
                    scan_col = scan_col - 1'b1;
                    wave     = WAVE_DATA;
                end
            end
            WAVE_LATCH_HI: begin
                pins.latch = 1'b1;
                pins.blank = 1'b1;
                wave       = WAVE_LATCH_LO;
            end
            WAVE_LATCH_LO: begin
                pins.latch = 1'b0;
                wave       = WAVE_UNBLANK;
            end
            WAVE_UNBLANK: begin
                pins.blank = 1'b0;
                on_left    = cfg_on;
                wave       = WAVE_ON_WAIT;
            end
            default: begin
                if (on_left != '0) begin
                    on_left    = on_left - 1'b1;
                    pins.blank = 1'b0;
                end else begin
                    // Sixteen row pairs: the 4-bit counter wraps on its own.
                    pins.blank = 1'b1;
                    scan_col   = '1;
                    scan_row   = scan_row + 1'b1;
                    wave       = WAVE_ADDR;
                end
            end
        endcase
    endtask

    // Apply one accepted item to the model and queue the pins it must produce.
    task automatic predict_pins(logic mode, logic [1:0] ch, logic [4:0] row,
                                logic [5:0] col, logic [7:0] val);
        if (mode == MODE_WRITE) begin
            if (ch != CHAN_SPARE) frame_bytes[{ch, row, col}] = val;
        end else begin
            advance_waveform();
        end
        pending_pins.push_back(pins);
    endtask

    // ------------------------------------------------------------------
    // Pixel/tick sender
    // ------------------------------------------------------------------

    // Presents one item and returns at the edge where it is accepted. Valid is
    // left high so back-to-back items need no extra assignment in one step.
    task automatic send_item(logic mode, logic [1:0] ch, logic [4:0] row,
                             logic [5:0] col, logic [7:0] val);
        pix_ch.valid       <= 1'b1;
        pix_ch.mode        <= mode;
        pix_ch.channel     <= ch;
        pix_ch.pixel_row   <= row;
        pix_ch.pixel_col   <= col;
        pix_ch.pixel_value <= val;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        predict_pins(mode, ch, row, col, val);
    endtask

    // A tick carries random noise in the pixel fields, which the unit must ignore.
    task automatic send_tick();
        send_item(MODE_TICK, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    endtask

    // A write aimed at the columns about to be shifted out, so that it shows up
    // on the data pins soon after.
    task automatic send_near_write();
        logic [7:0] val;
        logic [5:0] col;
        case ($urandom_range(0, 3))
            0:       val = 8'h00;
            1:       val = 8'hff;
            default: val = 8'($urandom_range(0, 255));
        endcase
        col = scan_col - 6'($urandom_range(0, 2));
        send_item(MODE_WRITE, 2'($urandom_range(0, 2)),
                  {1'($urandom_range(0, 1)), scan_row}, col, val);
    endtask

    task automatic send_any_write();
        send_item(MODE_WRITE, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    endtask

    task automatic pause_sender(int cycles);
        pix_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if (idle_on && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 10));
    endtask

    // Stop sending and wait for every owed transfer; the extra cycles cover the
    // two-stage pipeline so the unit is fully idle afterwards.
    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    task automatic apb_xfer(bit wr, logic idx, logic [LMRSD_PDATA_W-1:0] wdata,
                            output logic [LMRSD_PDATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_readback(logic idx, logic [LMRSD_PDATA_W-1:0] want);
        logic [LMRSD_PDATA_W-1:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h",
                   (idx == REG_BIT_PLANE) ? "bit_plane" : "on_ticks", want, got);
            err_count++;
        end
    endtask

    task automatic reg_write(logic idx, logic [LMRSD_PDATA_W-1:0] val);
        logic [LMRSD_PDATA_W-1:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        if (idx == REG_BIT_PLANE) cfg_plane = val[2:0];
        else                      cfg_on    = val[15:0];
        reg_readback(idx, val);
    endtask

    // Registers change only while nothing is in flight.
    task automatic set_config(logic [2:0] plane, logic [15:0] on_time);
        drain_results();
        reg_write(REG_BIT_PLANE, LMRSD_PDATA_W'(plane));
        reg_write(REG_ON_TICKS,  LMRSD_PDATA_W'(on_time));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values, byte extremes across the colour channels, a dropped write on
    // the spare channel and the first columns of the first row pair.
    task automatic test_directed();
        idle_on = 1'b1;
        reg_readback(REG_BIT_PLANE, 32'd7);
        reg_readback(REG_ON_TICKS,  32'd10);
        send_tick();                                              // row address phase
        send_item(MODE_WRITE, CHAN_RED,   5'd0,  6'd63, 8'h00);
        send_item(MODE_WRITE, CHAN_GREEN, 5'd16, 6'd63, 8'h80);
        send_item(MODE_WRITE, CHAN_BLUE,  5'd31, 6'd63, 8'hff);
        send_item(MODE_WRITE, CHAN_SPARE, 5'd0,  6'd63, 8'h00);  // must be dropped
        send_item(MODE_WRITE, CHAN_BLUE,  5'd0,  6'd63, 8'h7f);
        send_item(MODE_WRITE, CHAN_RED,   5'd16, 6'd63, 8'h01);
        send_item(MODE_WRITE, CHAN_RED,   5'd0,  6'd0,  8'h00);
        send_item(MODE_WRITE, CHAN_GREEN, 5'd31, 6'd0,  8'h55);
        send_item(MODE_WRITE, CHAN_BLUE,  5'd15, 6'd31, 8'haa);
        // Data, clock high and clock low for the top two columns.
        repeat (6) begin
            maybe_pause();
            send_tick();
        end
        send_item(MODE_WRITE, CHAN_GREEN, 5'd1,  6'd62, 8'h00);
        send_tick();
    endtask

    // Shortest on-time and the lowest plane: two row pairs' worth of ticks, so every
    // column is shifted, latched and the row address steps on.
    task automatic test_frame_sweep();
        int ticks;
        set_config(3'd0, 16'd0);
        ticks = 0;
        while (ticks < 2 * PAIR_TICKS) begin
            maybe_pause();
            if ($urandom_range(0, 5) == 0) begin
                send_near_write();
            end else begin
                send_tick();
                ticks++;
            end
        end
    endtask

    // Longer on-time: the unblanked wait must last the whole count.
    // Run without gaps to keep the cycle count down.
    task automatic test_long_on_time();
        idle_on = 1'b0;
        set_config(3'd7, 16'(LONG_ON_TICKS));
        repeat (PAIR_TICKS + LONG_ON_TICKS) send_tick();
        set_config(3'd4, 16'd1);
    endtask

    // Mostly ticks with writes landing in the scanned columns, some writes
    // anywhere. Register values change per phase; the last phase runs without gaps.
    task automatic test_random();
        int pick;
        for (int ph = 0; ph < 4; ph++) begin
            set_config(3'($urandom_range(0, 7)), 16'($urandom_range(0, 24)));
            idle_on = (ph != 3);
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // Once, hold the sender until the output side has caught up.
                if (ph == 1 && n == RANDOM_ITEMS / 2) drain_results();
                maybe_pause();
                pick = $urandom_range(0, 99);
                if (pick < 70)      send_tick();
                else if (pick < 90) send_near_write();
                else                send_any_write();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and the pin check
    // ------------------------------------------------------------------

    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                pin_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                pin_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic check_pin(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    // Every completed pin transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin : pin_check
        t_pins want;
        if (pin_ch.valid === 1'b1 && pin_ch.ready === 1'b1) begin
            if (pending_pins.size() == 0) begin
                $error("pin transfer with no levels expected");
                err_count++;
            end else begin
                want = pending_pins.pop_front();
                check_pin("row_addr",     want.row_addr,     pin_ch.row_addr);
                check_pin("red_top",      want.red_top,      pin_ch.red_top);
                check_pin("green_top",    want.green_top,    pin_ch.green_top);
                check_pin("blue_top",     want.blue_top,     pin_ch.blue_top);
                check_pin("red_bottom",   want.red_bottom,   pin_ch.red_bottom);
                check_pin("green_bottom", want.green_bottom, pin_ch.green_bottom);
                check_pin("blue_bottom",  want.blue_bottom,  pin_ch.blue_bottom);
                check_pin("shift_clock",  want.shift_clock,  pin_ch.shift_clock);
                check_pin("latch",        want.latch,        pin_ch.latch);
                check_pin("blank",        want.blank,        pin_ch.blank);
            end
        end
    end

    // A hang shows up as a long run of cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
            (pin_ch.valid === 1'b1 && pin_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.mode        <= MODE_WRITE;
        pix_ch.channel     <= CHAN_RED;
        pix_ch.pixel_row   <= '0;
        pix_ch.pixel_col   <= '0;
        pix_ch.pixel_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_panel_model();

        test_directed();
        test_frame_sweep();
        test_long_on_time();
        test_random();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
